// ===== hdl/kced_pkg.sv =====
// Package for the key click event detector: state and event encodings,
// configuration register indexes and reset values. It has no dependencies.
package kced_pkg;

    typedef enum logic [3:0] {
        ST_IDLE       = 4'd0,
        ST_PRESS_DEB  = 4'd1,
        ST_PRESSED    = 4'd2,
        ST_REL_DEB    = 4'd3,
        ST_RELEASED   = 4'd4,
        ST_CLICK_WAIT = 4'd5,
        ST_DPRESS_DEB = 4'd6,
        ST_DREL_DEB   = 4'd7,
        ST_CLICK      = 4'd8,
        ST_DOUBLE     = 4'd9,
        ST_LONG       = 4'd10,
        ST_REPEAT     = 4'd11,
        ST_LOCK       = 4'd12
    } fsm_state_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_CLICK  = 3'd1,
        EV_LONG   = 3'd2,
        EV_REPEAT = 3'd3,
        EV_DOUBLE = 3'd4
    } key_event_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int TIME_W      = 32;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
    typedef logic [TIME_W-1:0]      tick_t;

    localparam cfg_index_t REG_DEBOUNCE_TIME   = 3'd0;
    localparam cfg_index_t REG_LONG_PRESS_TIME = 3'd1;
    localparam cfg_index_t REG_REPEAT_PERIOD   = 3'd2;
    localparam cfg_index_t REG_DOUBLE_WINDOW   = 3'd3;
    localparam cfg_index_t REG_LOCKOUT_TIME    = 3'd4;

    localparam cfg_data_t DEBOUNCE_TIME_RST   = 16'd20;
    localparam cfg_data_t LONG_PRESS_TIME_RST = 16'd1000;
    localparam cfg_data_t REPEAT_PERIOD_RST   = 16'd200;
    localparam cfg_data_t DOUBLE_WINDOW_RST   = 16'd300;
    localparam cfg_data_t LOCKOUT_TIME_RST    = 16'd300;

endpackage

// ===== hdl/key_click_event_detector_top.sv =====
// Top level of the key click event detector: configuration registers, input
// register, event state machine and result register. Depends on kced_pkg.
//
//   Channel   Direction  Handshake            Payload
//   -------   ---------  -------------------  --------------------
//   input     in         in_valid / in_stall  key_down, now_time
//   result    out        out_valid/out_stall  event_code
//   config    in         cfg_we               cfg_index, cfg_data
//
// One input transaction can be accepted in every cycle while in_stall is
// low. Each accepted transaction yields exactly one result transaction:
// it waits in the input register, then the state machine step writes the
// result register. The step itself is one 32-bit wrapping subtract and a
// few 32-bit compares. Reset clears the state machine to idle, the marked
// time to zero, both valid flags to zero and the configuration registers
// to their default values. While the result is stalled the input register
// still takes one more transaction, after which in_stall rises.
module key_click_event_detector_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                key_down,
    input  kced_pkg::tick_t     now_time,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          event_code,
    input  logic                cfg_we,
    input  kced_pkg::cfg_index_t cfg_index,
    input  kced_pkg::cfg_data_t cfg_data
);
    import kced_pkg::*;

    // Configuration registers.
    cfg_data_t debounce_time_reg;
    cfg_data_t long_press_time_reg;
    cfg_data_t repeat_period_reg;
    cfg_data_t double_window_reg;
    cfg_data_t lockout_time_reg;

    // Input register.
    logic  in_valid_reg;
    logic  key_down_reg;
    tick_t now_time_reg;

    // Machine state.
    fsm_state_t state_reg, state_next;
    fsm_state_t return_reg, return_next;
    tick_t      mark_reg, mark_next;

    // Result register.
    logic       out_valid_reg;
    key_event_t event_reg, event_next;

    logic  out_load;
    logic  step;
    logic  in_accept;
    tick_t elapsed;
    tick_t debounce_w, long_w, repeat_w, window_w, lockout_w;

    // The result register can load when it is empty or being drained.
    assign out_load  = !out_valid_reg || !out_stall;
    assign step      = in_valid_reg && out_load;
    assign in_stall  = in_valid_reg && !out_load;
    assign in_accept = in_valid && !in_stall;

    assign elapsed    = now_time_reg - mark_reg;
    assign debounce_w = {16'd0, debounce_time_reg};
    assign long_w     = {16'd0, long_press_time_reg};
    assign repeat_w   = {16'd0, repeat_period_reg};
    assign window_w   = {16'd0, double_window_reg};
    assign lockout_w  = {16'd0, lockout_time_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            debounce_time_reg   <= DEBOUNCE_TIME_RST;
            long_press_time_reg <= LONG_PRESS_TIME_RST;
            repeat_period_reg   <= REPEAT_PERIOD_RST;
            double_window_reg   <= DOUBLE_WINDOW_RST;
            lockout_time_reg    <= LOCKOUT_TIME_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DEBOUNCE_TIME:   debounce_time_reg   <= cfg_data;
                REG_LONG_PRESS_TIME: long_press_time_reg <= cfg_data;
                REG_REPEAT_PERIOD:   repeat_period_reg   <= cfg_data;
                REG_DOUBLE_WINDOW:   double_window_reg   <= cfg_data;
                REG_LOCKOUT_TIME:    lockout_time_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Next-state logic for one polling step. Codes outside the state list
    // fall back to idle.
    always_comb begin
        state_next  = state_reg;
        return_next = return_reg;
        mark_next   = mark_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (key_down_reg) begin
                    mark_next  = now_time_reg;
                    state_next = ST_PRESS_DEB;
                end
            end
            ST_PRESS_DEB: begin
                if (!key_down_reg) begin
                    state_next = ST_IDLE;
                end else if (elapsed > debounce_w) begin
                    state_next = ST_PRESSED;
                end
            end
            ST_PRESSED: begin
                if (!key_down_reg) begin
                    mark_next   = now_time_reg;
                    return_next = ST_PRESSED;
                    state_next  = ST_REL_DEB;
                end else if (elapsed >= long_w) begin
                    state_next = ST_LONG;
                end
            end
            ST_REL_DEB: begin
                if (key_down_reg) begin
                    state_next = return_reg;
                end else if (elapsed > debounce_w) begin
                    state_next = (return_reg == ST_PRESSED) ? ST_RELEASED : ST_IDLE;
                end
            end
            ST_RELEASED: begin
                if (double_window_reg != '0) begin
                    mark_next  = now_time_reg;
                    state_next = ST_CLICK_WAIT;
                end else begin
                    state_next = ST_CLICK;
                end
            end
            ST_CLICK_WAIT: begin
                if (key_down_reg) begin
                    mark_next  = now_time_reg;
                    state_next = ST_DPRESS_DEB;
                end else if (elapsed >= window_w) begin
                    state_next = ST_CLICK;
                end
            end
            ST_DPRESS_DEB: begin
                if (key_down_reg) begin
                    if (elapsed > debounce_w) begin
                        mark_next  = now_time_reg;
                        state_next = ST_DREL_DEB;
                    end
                end else begin
                    mark_next  = now_time_reg;
                    state_next = ST_CLICK_WAIT;
                end
            end
            ST_DREL_DEB: begin
                if (elapsed <= window_w) begin
                    if (!key_down_reg && (elapsed > debounce_w)) begin
                        state_next = ST_DOUBLE;
                    end
                end else if (!key_down_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLICK: begin
                state_next = ST_IDLE;
            end
            ST_DOUBLE: begin
                mark_next  = now_time_reg;
                state_next = ST_LOCK;
            end
            ST_LONG: begin
                mark_next  = now_time_reg;
                state_next = ST_REPEAT;
            end
            ST_REPEAT: begin
                if (!key_down_reg) begin
                    // The release debounce is timed from the release itself.
                    mark_next   = now_time_reg;
                    return_next = ST_REPEAT;
                    state_next  = ST_REL_DEB;
                end else if (elapsed >= repeat_w) begin
                    mark_next = now_time_reg;
                end
            end
            ST_LOCK: begin
                if (elapsed > lockout_w) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Event output for the same step.
    always_comb begin
        event_next = EV_NONE;
        unique case (state_reg)
            ST_CLICK:  event_next = EV_CLICK;
            ST_DOUBLE: event_next = EV_DOUBLE;
            ST_LONG:   event_next = EV_LONG;
            ST_REPEAT: begin
                if (key_down_reg && (elapsed >= repeat_w)) begin
                    event_next = EV_REPEAT;
                end
            end
            default:   event_next = EV_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_IDLE;
            return_reg    <= ST_IDLE;
            mark_reg      <= '0;
        end else begin
            if (in_accept) begin
                in_valid_reg <= 1'b1;
            end else if (step) begin
                in_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
            if (step) begin
                state_reg  <= state_next;
                return_reg <= return_next;
                mark_reg   <= mark_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk) begin
        if (in_accept) begin
            key_down_reg <= key_down;
            now_time_reg <= now_time;
        end
        if (step) begin
            event_reg <= event_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_code = event_reg;

    // The machine state only moves when a transaction is stepped.
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(state_reg) && $stable(mark_reg))
        else $error("machine state changed without a step");

    // A step from the click state always delivers a click next.
    a_click_out: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (state_reg == ST_CLICK)) |=> out_valid && (event_code == EV_CLICK))
        else $error("click state did not produce a click event");

    // Input is stalled only while the input register holds a transaction.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg)
        else $error("input stalled with room in the pipeline");

    // The saved return state is only ever pressed, long repeat or idle.
    a_return_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (return_reg == ST_IDLE) || (return_reg == ST_PRESSED) || (return_reg == ST_REPEAT))
        else $error("illegal saved return state");

endmodule

// ===== bench/kced_event_checker.sv =====
// Checker for the key click event detector: watches the poll, result and
// config channels, predicts each event code and compares. Depends on kced_pkg.
module kced_event_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 key_down,
    input  kced_pkg::tick_t      now_time,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [2:0]           event_code,
    input  logic                 cfg_we,
    input  kced_pkg::cfg_index_t cfg_index,
    input  kced_pkg::cfg_data_t  cfg_data,
    output int                   mismatch_count,
    output int                   events_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import kced_pkg::*;

    // Shadow copy of the detector: settings, state and marked time.
    cfg_data_t  debounce_ticks;
    cfg_data_t  long_ticks;
    cfg_data_t  repeat_ticks;
    cfg_data_t  window_ticks;
    cfg_data_t  lock_ticks;
    fsm_state_t shadow_state;
    fsm_state_t saved_state;
    tick_t      mark_tick;

    key_event_t expected_events[$];
    int         mismatches = 0;
    int         pending_count = 0;

    assign mismatch_count = mismatches;
    assign events_pending = pending_count;

    // One poll of the key: advances the shadow state, returns the event.
    function automatic key_event_t predict_key_event(input logic down, input tick_t now);
        tick_t      elapsed;
        key_event_t ev;
        elapsed = now - mark_tick;
        ev = EV_NONE;
        case (shadow_state)
            ST_IDLE:
                if (down)
                begin
                    mark_tick = now;
                    shadow_state = ST_PRESS_DEB;
                end
            ST_PRESS_DEB:
                if (!down)
                    shadow_state = ST_IDLE;
                else if (elapsed > debounce_ticks)
                    shadow_state = ST_PRESSED;
            ST_PRESSED:
                if (!down)
                begin
                    mark_tick = now;
                    saved_state = ST_PRESSED;
                    shadow_state = ST_REL_DEB;
                end
                else if (elapsed >= long_ticks)
                    shadow_state = ST_LONG;
            ST_REL_DEB:
                if (down)
                    shadow_state = saved_state;
                else if (elapsed > debounce_ticks)
                begin
                    // Only a release from a plain press leads on to a click.
                    if (saved_state == ST_PRESSED)
                        shadow_state = ST_RELEASED;
                    else
                        shadow_state = ST_IDLE;
                end
            ST_RELEASED:
                if (window_ticks != 0)
                begin
                    mark_tick = now;
                    shadow_state = ST_CLICK_WAIT;
                end
                else
                    shadow_state = ST_CLICK;
            ST_CLICK_WAIT:
                if (down)
                begin
                    mark_tick = now;
                    shadow_state = ST_DPRESS_DEB;
                end
                else if (elapsed >= window_ticks)
                    shadow_state = ST_CLICK;
            ST_DPRESS_DEB:
                if (down)
                begin
                    if (elapsed > debounce_ticks)
                    begin
                        mark_tick = now;
                        shadow_state = ST_DREL_DEB;
                    end
                end
                else
                begin
                    mark_tick = now;
                    shadow_state = ST_CLICK_WAIT;
                end
            ST_DREL_DEB:
                if (elapsed <= window_ticks)
                begin
                    if (!down && elapsed > debounce_ticks)
                        shadow_state = ST_DOUBLE;
                end
                else if (!down)
                    shadow_state = ST_IDLE;
            ST_CLICK:
            begin
                ev = EV_CLICK;
                shadow_state = ST_IDLE;
            end
            ST_DOUBLE:
            begin
                ev = EV_DOUBLE;
                mark_tick = now;
                shadow_state = ST_LOCK;
            end
            ST_LONG:
            begin
                ev = EV_LONG;
                mark_tick = now;
                shadow_state = ST_REPEAT;
            end
            ST_REPEAT:
                if (!down)
                begin
                    mark_tick = now;
                    saved_state = ST_REPEAT;
                    shadow_state = ST_REL_DEB;
                end
                else if (elapsed >= repeat_ticks)
                begin
                    ev = EV_REPEAT;
                    mark_tick = now;
                end
            ST_LOCK:
                if (elapsed > lock_ticks)
                    shadow_state = ST_IDLE;
            default:
                shadow_state = ST_IDLE;
        endcase
        return ev;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        key_event_t want;
        if (!rst_n)
        begin
            debounce_ticks = DEBOUNCE_TIME_RST;
            long_ticks     = LONG_PRESS_TIME_RST;
            repeat_ticks   = REPEAT_PERIOD_RST;
            window_ticks   = DOUBLE_WINDOW_RST;
            lock_ticks     = LOCKOUT_TIME_RST;
            shadow_state   = ST_IDLE;
            saved_state    = ST_IDLE;
            mark_tick      = '0;
            expected_events.delete();
            pending_count  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%t: unexpected result, event_code %0d with none pending",
                                 $realtime, event_code);
                    mismatches++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (event_code !== want)
                    begin
                        if (mismatches < 10)
                            $display("%t: event_code mismatch, expected %0d got %0d",
                                     $realtime, want, event_code);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_events.push_back(predict_key_event(key_down, now_time));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEBOUNCE_TIME:   debounce_ticks = cfg_data;
                    REG_LONG_PRESS_TIME: long_ticks     = cfg_data;
                    REG_REPEAT_PERIOD:   repeat_ticks   = cfg_data;
                    REG_DOUBLE_WINDOW:   window_ticks   = cfg_data;
                    REG_LOCKOUT_TIME:    lock_ticks     = cfg_data;
                    default:             ;
                endcase
            end
            pending_count = expected_events.size();
        end
    end

endmodule

// ===== bench/key_click_event_detector_top_tb.sv =====
// Testbench top for the key click event detector: clock, reset, poll and
// setting stimulus, verdict. Depends on kced_pkg, key_click_event_detector_top
// and kced_event_checker.
module key_click_event_detector_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import kced_pkg::*;

    // A run stuck for this many cycles without any transaction is a hang.
    localparam int WATCHDOG_LIMIT = 2000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       key_down = 1'b0;
    tick_t      now_time = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] event_code;
    logic       cfg_we = 1'b0;
    cfg_index_t cfg_index = '0;
    cfg_data_t  cfg_data = '0;

    int mismatch_count;
    int events_pending;

    // Stimulus bookkeeping. The cfg_* copies only shape the key gestures;
    // the checker keeps its own copy of the settings for prediction.
    tick_t       tick;
    int unsigned step_max;
    bit          steady = 1'b0;
    int          polls_sent = 0;
    int          idle_cycles = 0;
    int unsigned cfg_deb = DEBOUNCE_TIME_RST;
    int unsigned cfg_lp = LONG_PRESS_TIME_RST;
    int unsigned cfg_rp = REPEAT_PERIOD_RST;
    int unsigned cfg_win = DOUBLE_WINDOW_RST;
    int unsigned cfg_lock = LOCKOUT_TIME_RST;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    key_click_event_detector_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key_down   (key_down),
        .now_time   (now_time),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_code (event_code),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    kced_event_checker event_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .key_down       (key_down),
        .now_time       (now_time),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_code     (event_code),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .events_pending (events_pending)
    );

    // The result side stalls with a chance of 31 in a hundred, except during
    // a steady stretch where neither side holds back.
    always @(negedge clk)
    begin
        if (!rst_n || steady)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 31);
    end

    // Watchdog: any accepted transaction or setting write restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Offers one poll and returns at the falling edge after it was taken.
    // A random idle gap may come first; valid is only ever changed once per
    // falling edge, so a back-to-back poll keeps it high without a glitch.
    task automatic send_poll(input logic down, input tick_t t);
        int gap;
        if (!steady && $urandom_range(0, 99) < 31)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        key_down <= down;
        now_time <= t;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        polls_sent++;
    endtask

    // Keeps the key at one level for at least dur ticks of the running
    // timestamp, which advances by a random step after every poll. Steps of
    // zero repeat the same timestamp.
    task automatic hold_level(input logic down, input int unsigned dur);
        tick_t start;
        start = tick;
        do
        begin
            send_poll(down, tick);
            tick += tick_t'($urandom_range(0, step_max));
        end
        while (tick - start <= dur);
    endtask

    // Stops sending and waits until every pending result has come back,
    // then lets the two-stage pipeline go quiet.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (events_pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
    endtask

    // Loads all five settings, then hits the unused indexes with random
    // data, which the block must ignore. Only called while the block is idle.
    task automatic load_settings(input cfg_data_t deb, input cfg_data_t lp, input cfg_data_t rp,
                                 input cfg_data_t win, input cfg_data_t lock);
        write_reg(REG_DEBOUNCE_TIME, deb);
        write_reg(REG_LONG_PRESS_TIME, lp);
        write_reg(REG_REPEAT_PERIOD, rp);
        write_reg(REG_DOUBLE_WINDOW, win);
        write_reg(REG_LOCKOUT_TIME, lock);
        for (int i = int'(REG_LOCKOUT_TIME) + 1; i < (1 << CFG_INDEX_W); i++)
            write_reg(cfg_index_t'(i), cfg_data_t'($urandom()));
        cfg_we <= 1'b0;
        cfg_deb = deb;
        cfg_lp = lp;
        cfg_rp = rp;
        cfg_win = win;
        cfg_lock = lock;
    endtask

    // One gesture of the user. Most are well-formed clicks, double clicks
    // and long presses whose hold times sit around the current settings, so
    // the debounce, window and lockout edges get hit from both sides. The
    // rest is contact bounce, random noise with timestamp jumps, and rest.
    task automatic key_gesture();
        int unsigned kind;
        kind = $urandom_range(0, 9);
        case (kind) inside
            [0:2]:
            begin
                hold_level(1'b1, cfg_deb + 1 + $urandom_range(0, cfg_lp));
                hold_level(1'b0, cfg_deb + 1 + cfg_win + $urandom_range(0, 2 * step_max));
            end
            [3:4]:
            begin
                hold_level(1'b1, cfg_deb + 1 + $urandom_range(0, cfg_lp / 2));
                hold_level(1'b0, cfg_deb + 1 + $urandom_range(0, cfg_win / 2));
                hold_level(1'b1, cfg_deb + 1 + $urandom_range(0, cfg_win / 2));
                hold_level(1'b0, cfg_deb + 1 + $urandom_range(0, cfg_win + cfg_lock));
                hold_level(1'b0, $urandom_range(0, cfg_lock + 2 * step_max));
            end
            [5:6]:
            begin
                hold_level(1'b1, cfg_lp + $urandom_range(0, 2 * cfg_rp + 4 * step_max));
                hold_level(1'b0, cfg_deb + 1 + cfg_win + $urandom_range(0, 2 * step_max));
            end
            7:
                repeat ($urandom_range(2, 6))
                    hold_level(1'($urandom_range(0, 1)), $urandom_range(0, cfg_deb + step_max));
            8:
                repeat ($urandom_range(2, 8))
                begin
                    if ($urandom_range(0, 3) == 0)
                        tick = $urandom();
                    send_poll(1'($urandom_range(0, 1)), tick);
                    tick += tick_t'($urandom_range(0, 2 * step_max));
                end
            default:
                hold_level(1'b0, $urandom_range(0, cfg_win + cfg_lock + cfg_deb));
        endcase
    endtask

    // A block of random gestures under the current settings. The timestamp
    // starts anywhere, sometimes just short of the wrap.
    task automatic run_phase(input int quota, input int unsigned step_cap, input bit no_gaps);
        int start_count;
        step_max = step_cap;
        steady = no_gaps;
        if ($urandom_range(0, 1) == 0)
            tick = $urandom();
        else
            tick = '1 - tick_t'($urandom_range(0, 500));
        start_count = polls_sent;
        while (polls_sent - start_count < quota)
            key_gesture();
        steady = 1'b0;
        drain_results();
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed polls under the reset settings (debounce 20, long press
        // 1000, repeat 200, window 300, lockout 300). First a press that
        // straddles the timestamp wrap, held into a long press and a repeat,
        // with a bounce during the release from repeat.
        send_poll(1'b0, 32'h0000_0000);
        send_poll(1'b1, 32'hFFFF_FFF0);
        send_poll(1'b1, 32'h0000_0004);   // exactly the debounce time: not yet
        send_poll(1'b1, 32'h0000_0005);   // one tick beyond: press confirmed
        send_poll(1'b1, 32'h0000_03D8);   // held exactly the long-press time
        send_poll(1'b1, 32'h0000_0500);   // long press reported
        send_poll(1'b1, 32'h0000_05C8);   // one repeat period later
        send_poll(1'b0, 32'h0000_0600);
        send_poll(1'b1, 32'h0000_0601);   // bounce goes back to repeating
        send_poll(1'b0, 32'h0000_0610);
        send_poll(1'b0, 32'h0000_0625);   // release from repeat ends in idle

        // A double click followed by the lockout, leaving it one tick late.
        send_poll(1'b1, 32'hFFFF_FFFF);
        send_poll(1'b1, 32'h0000_0015);
        send_poll(1'b0, 32'h0000_0020);
        send_poll(1'b0, 32'h0000_0040);
        send_poll(1'b0, 32'h0000_0041);
        send_poll(1'b1, 32'h0000_0050);
        send_poll(1'b1, 32'h0000_0070);
        send_poll(1'b0, 32'h0000_0090);
        send_poll(1'b0, 32'h0000_0091);   // double click reported, lock starts
        send_poll(1'b0, 32'h0000_01BE);

        // A single click whose window runs out exactly at its length.
        send_poll(1'b1, 32'h0000_0200);
        send_poll(1'b1, 32'h0000_0220);
        send_poll(1'b0, 32'h0000_0230);
        send_poll(1'b0, 32'h0000_0250);
        send_poll(1'b0, 32'h0000_0251);
        send_poll(1'b0, 32'h0000_037D);
        send_poll(1'b0, 32'h0000_0380);   // click reported
        drain_results();

        // Random gestures under several settings, extremes included. Each
        // phase ends with the sender paused until every result is back, so
        // the settings only change while the block is idle. A phase runs its
        // last gesture to the end, so the quotas leave room for that.
        run_phase(70, 25, 1'b0);
        load_settings(16'd3, 16'd40, 16'd10, 16'd15, 16'd12);
        run_phase(120, 2, 1'b1);
        load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_phase(100, 2, 1'b0);
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(50, 4000, 1'b0);
        load_settings(16'd2, 16'd30, 16'd0, 16'd0, 16'd5);
        run_phase(110, 2, 1'b0);
        load_settings(cfg_data_t'($urandom_range(0, 40)), cfg_data_t'($urandom_range(0, 40)),
                      cfg_data_t'($urandom_range(0, 40)), cfg_data_t'($urandom_range(0, 40)),
                      cfg_data_t'($urandom_range(0, 40)));
        run_phase(70, 3, 1'b0);
        run_phase(70, 3, 1'b0);

        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && events_pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/kced_pkg.sv
hdl/key_click_event_detector_top.sv
bench/kced_event_checker.sv
bench/key_click_event_detector_top_tb.sv
